// ----- design/orsk_pkg.sv -----
`timescale 1ns / 1ps

package orsk_pkg;

  // fixed field widths
  localparam int unsigned UID_W    = 8;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_W    = 32;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_MISS  = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN
  } state_e;

  // result request from the sequencer to the output stage
  typedef struct packed {
    logic    valid;
    status_e status;
    logic    hit;
  } res_t;

endpackage

// ----- design/overwrite_ring_stack_key_lookup_core.sv -----
`timescale 1ns / 1ps

// Ring stack of DEPTH slots holding up to DEPTH-1 entries (uid plus data word);
// a push into a full ring drops the oldest entry. An item is taken when start_i
// is high and busy_o is low; its single result shows on the result ports for
// one cycle with done_o high, in the cycle after the last step of the item, and
// must be taken then since the receiver cannot stall. Push, unused op codes and
// pop or lookup on an empty ring finish in the idle state; a pop reads the
// newest entry and reports it from the pop state; a lookup compares entries
// oldest to newest until a hit or the end of the valid range (at most DEPTH-1
// entries) through the memory's single port and the one reused uid comparator.
module overwrite_ring_stack_key_lookup_core #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [orsk_pkg::OP_W-1:0]           op_i,
  input  logic [orsk_pkg::UID_W-1:0]          key_uid_i,
  input  logic [orsk_pkg::OUT_W-1:0]          entry_data_i,
  output logic                                done_o,
  output logic [orsk_pkg::STATUS_W-1:0]       status_o,
  output logic [orsk_pkg::UID_W-1:0]          out_uid_o,
  output logic [orsk_pkg::OUT_W-1:0]          out_data_o
);

  localparam int unsigned EW = orsk_pkg::UID_W + DATA_WIDTH;
  localparam int unsigned KW = (DATA_WIDTH < orsk_pkg::OUT_W) ? DATA_WIDTH : orsk_pkg::OUT_W;

  logic                        ram_we;
  logic [$clog2(DEPTH)-1:0]    ram_addr;
  logic [EW-1:0]               ram_wdata;
  logic [EW-1:0]               ram_rdata;
  logic [orsk_pkg::UID_W-1:0]  rd_uid;
  logic [DATA_WIDTH-1:0]       rd_data;
  logic [DATA_WIDTH-1:0]       wr_data;
  orsk_pkg::res_t              res;

  logic                           done_q;
  logic [orsk_pkg::STATUS_W-1:0]  status_q;
  logic [orsk_pkg::UID_W-1:0]     uid_q;
  logic [orsk_pkg::OUT_W-1:0]     data_q;

  // entry packing: uid above data
  assign wr_data   = DATA_WIDTH'(entry_data_i[KW-1:0]);
  assign ram_wdata = {key_uid_i, wr_data};
  assign rd_uid    = ram_rdata[EW-1 -: orsk_pkg::UID_W];
  assign rd_data   = ram_rdata[DATA_WIDTH-1:0];

  orsk_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  orsk_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .op_i       (op_i),
    .key_uid_i  (key_uid_i),
    .rd_uid_i   (rd_uid),
    .busy_o     (busy_o),
    .ram_we_o   (ram_we),
    .ram_addr_o (ram_addr),
    .res_o      (res)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res.valid;
    end
  end

  // result payload, zero unless an entry was returned
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      uid_q    <= res.hit ? rd_uid : '0;
      data_q   <= res.hit ? orsk_pkg::OUT_W'(rd_data[KW-1:0]) : '0;
    end
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign out_uid_o  = uid_q;
  assign out_data_o = data_q;

endmodule

// ----- design/orsk_ram.sv -----
`timescale 1ns / 1ps

module orsk_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/orsk_ctrl.sv -----
`timescale 1ns / 1ps

module orsk_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [orsk_pkg::OP_W-1:0]       op_i,
  input  logic [orsk_pkg::UID_W-1:0]      key_uid_i,
  input  logic [orsk_pkg::UID_W-1:0]      rd_uid_i,
  output logic                            busy_o,
  output logic                            ram_we_o,
  output logic [$clog2(DEPTH)-1:0]        ram_addr_o,
  output orsk_pkg::res_t                  res_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  orsk_pkg::state_e state_q, state_d;
  logic [PW-1:0] newest_q, newest_d;
  logic [PW-1:0] oldest_q, oldest_d;
  logic [PW-1:0] scan_q, scan_d;
  logic [orsk_pkg::UID_W-1:0] key_q, key_d;
  logic accept;
  logic empty;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
    ring_prev = (p == '0) ? LAST : p - 1'b1;
  endfunction

  assign busy_o = (state_q != orsk_pkg::S_IDLE);
  assign accept = start_i && !busy_o;
  assign empty  = (newest_q == oldest_q);

  // state and pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= orsk_pkg::S_IDLE;
      newest_q <= '0;
      oldest_q <= '0;
    end else begin
      state_q  <= state_d;
      newest_q <= newest_d;
      oldest_q <= oldest_d;
    end
  end

  // scan pointer and search key
  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    key_q  <= key_d;
  end

  // sequencer: one ram access and one uid compare per cycle
  always_comb begin
    state_d    = state_q;
    newest_d   = newest_q;
    oldest_d   = oldest_q;
    scan_d     = scan_q;
    key_d      = key_q;
    ram_we_o   = 1'b0;
    ram_addr_o = newest_q;
    res_o      = '{valid: 1'b0, status: orsk_pkg::ST_OK, hit: 1'b0};
    unique case (state_q)
      orsk_pkg::S_IDLE: begin
        if (accept) begin
          key_d = key_uid_i;
          unique case (orsk_pkg::op_e'(op_i))
            orsk_pkg::OP_PUSH: begin
              newest_d   = ring_next(newest_q);
              ram_we_o   = 1'b1;
              ram_addr_o = newest_d;
              if (newest_d == oldest_q) begin
                oldest_d = ring_next(oldest_q);
              end
              res_o.valid = 1'b1;
            end
            orsk_pkg::OP_POP: begin
              if (empty) begin
                res_o.valid  = 1'b1;
                res_o.status = orsk_pkg::ST_EMPTY;
              end else begin
                ram_addr_o = newest_q;
                newest_d   = ring_prev(newest_q);
                state_d    = orsk_pkg::S_POP;
              end
            end
            orsk_pkg::OP_LOOKUP: begin
              if (empty) begin
                res_o.valid  = 1'b1;
                res_o.status = orsk_pkg::ST_MISS;
              end else begin
                scan_d     = ring_next(oldest_q);
                ram_addr_o = scan_d;
                state_d    = orsk_pkg::S_SCAN;
              end
            end
            default: begin
              // unused op code, plain ok result
              res_o.valid = 1'b1;
            end
          endcase
        end
      end
      orsk_pkg::S_POP: begin
        res_o.valid = 1'b1;
        res_o.hit   = 1'b1;
        state_d     = orsk_pkg::S_IDLE;
      end
      orsk_pkg::S_SCAN: begin
        // compare the entry read last cycle, oldest to newest
        if (rd_uid_i == key_q) begin
          res_o.valid = 1'b1;
          res_o.hit   = 1'b1;
          state_d     = orsk_pkg::S_IDLE;
        end else if (scan_q == newest_q) begin
          res_o.valid  = 1'b1;
          res_o.status = orsk_pkg::ST_MISS;
          state_d      = orsk_pkg::S_IDLE;
        end else begin
          scan_d     = ring_next(scan_q);
          ram_addr_o = scan_d;
        end
      end
      default: begin
        state_d = orsk_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- test/tb_overwrite_ring_stack_key_lookup_core.sv -----
`timescale 1ns / 1ps

module tb_overwrite_ring_stack_key_lookup_core;
  import orsk_pkg::*;

  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned DATA_W     = 32;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // one result as the block reports it
  typedef struct {
    status_e           st;
    logic [UID_W-1:0]  uid;
    logic [OUT_W-1:0]  data;
  } ring_result_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                start_i      = 1'b0;
  logic [OP_W-1:0]     op_i         = '0;
  logic [UID_W-1:0]    key_uid_i    = '0;
  logic [OUT_W-1:0]    entry_data_i = '0;
  logic                busy_o;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [UID_W-1:0]    out_uid_o;
  logic [OUT_W-1:0]    out_data_o;

  // shadow copy of the ring
  logic [UID_W-1:0]  ring_uid  [RING_DEPTH];
  logic [DATA_W-1:0] ring_data [RING_DEPTH];
  int unsigned       newest_ptr;
  int unsigned       oldest_mark;

  ring_result_t pending_ring_results[$];
  ring_result_t head_result;
  int           err_cnt;
  bit           no_idle;

  overwrite_ring_stack_key_lookup_core #(
    .DEPTH      (RING_DEPTH),
    .DATA_WIDTH (DATA_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .key_uid_i    (key_uid_i),
    .entry_data_i (entry_data_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .out_uid_o    (out_uid_o),
    .out_data_o   (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // ring arithmetic with wrap
  function automatic int unsigned ring_next(input int unsigned p);
    return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic int unsigned ring_fill();
    return (newest_ptr + RING_DEPTH - oldest_mark) % RING_DEPTH;
  endfunction

  // applies one item to the shadow ring and returns the result it should give
  function automatic ring_result_t predict_ring_result(input logic [OP_W-1:0] op,
                                                      input logic [UID_W-1:0] uid,
                                                      input logic [OUT_W-1:0] data);
    ring_result_t res;
    int unsigned  p;
    bit           found;
    res.st   = ST_OK;
    res.uid  = '0;
    res.data = '0;
    case (op)
      OP_PUSH: begin
        newest_ptr = ring_next(newest_ptr);
        if (newest_ptr == oldest_mark) oldest_mark = ring_next(oldest_mark);
        ring_uid[newest_ptr]  = uid;
        ring_data[newest_ptr] = data[DATA_W-1:0];
      end
      OP_POP: begin
        if (newest_ptr == oldest_mark) begin
          res.st = ST_EMPTY;
        end else begin
          res.uid    = ring_uid[newest_ptr];
          res.data   = ring_data[newest_ptr];
          newest_ptr = (newest_ptr == 0) ? RING_DEPTH - 1 : newest_ptr - 1;
        end
      end
      OP_LOOKUP: begin
        // oldest first, so duplicates resolve to the oldest entry
        p     = oldest_mark;
        found = 1'b0;
        while (p != newest_ptr && !found) begin
          p = ring_next(p);
          if (ring_uid[p] == uid) begin
            found    = 1'b1;
            res.uid  = ring_uid[p];
            res.data = ring_data[p];
          end
        end
        if (!found) res.st = ST_MISS;
      end
      default: ;
    endcase
    return res;
  endfunction

  // uid of a random live entry, or any uid when the ring is empty
  function automatic logic [UID_W-1:0] live_uid();
    int unsigned n;
    n = ring_fill();
    if (n == 0) return UID_W'($urandom_range(0, 255));
    return ring_uid[(oldest_mark + $urandom_range(1, n)) % RING_DEPTH];
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sends one item and records what it should produce
  task automatic send_item(input logic [OP_W-1:0] op, input logic [UID_W-1:0] uid,
                           input logic [OUT_W-1:0] data);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    op_i         <= op;
    key_uid_i    <= uid;
    entry_data_i <= data;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_ring_results.push_back(predict_ring_result(op, uid, data));
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_ring_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d uid=%h data=%h",
                 $realtime, status_o, out_uid_o, out_data_o);
        err_cnt++;
      end else begin
        head_result = pending_ring_results.pop_front();
        if (status_o !== head_result.st) begin
          $display("%0t: status expected %0d actual %0d", $realtime, head_result.st,
                   status_o);
          err_cnt++;
        end
        if (out_uid_o !== head_result.uid) begin
          $display("%0t: uid expected %h actual %h", $realtime, head_result.uid,
                   out_uid_o);
          err_cnt++;
        end
        if (out_data_o !== head_result.data) begin
          $display("%0t: data expected %h actual %h", $realtime, head_result.data,
                   out_data_o);
          err_cnt++;
        end
      end
    end
  end

  // empty ring: pop, lookup and the unused op code
  task automatic test_empty_ring();
    send_item(OP_POP, 8'h00, 32'h0);
    send_item(OP_LOOKUP, 8'h00, 32'h0);
    send_item(OP_UNUSED, 8'h00, 32'h0);
  endtask

  // field extremes, duplicate uids, hits and misses
  task automatic test_push_lookup();
    send_item(OP_PUSH, 8'h00, 32'h0000_0000);
    send_item(OP_PUSH, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_PUSH, 8'h5A, 32'hA5A5_A5A5);
    send_item(OP_PUSH, 8'hA5, 32'h5A5A_5A5A);
    send_item(OP_PUSH, 8'h5A, 32'h1234_5678);
    send_item(OP_LOOKUP, 8'h5A, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 8'hFF, 32'h0);
    send_item(OP_LOOKUP, 8'h00, 32'h0);
    send_item(OP_LOOKUP, 8'h33, 32'h0);
    send_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
  endtask

  // pop everything back out, then one pop and lookup past empty
  task automatic test_pop_drain();
    send_item(OP_POP, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 8'h5A, 32'h0);
    repeat (4) send_item(OP_POP, 8'h00, 32'h0);
    send_item(OP_POP, 8'h00, 32'h0);
    send_item(OP_LOOKUP, 8'hA5, 32'h0);
  endtask

  // fill past capacity so the oldest entries are dropped, then drain
  task automatic test_overwrite(input int unsigned extra);
    logic [UID_W-1:0] first_uid;
    first_uid = UID_W'($urandom_range(0, 255));
    send_item(OP_PUSH, first_uid, $urandom);
    repeat (RING_DEPTH - 2 + extra)
      send_item(OP_PUSH, UID_W'($urandom_range(0, 255)), $urandom);
    send_item(OP_LOOKUP, first_uid, $urandom);
    repeat (6) send_item(OP_LOOKUP, live_uid(), $urandom);
    while (ring_fill() != 0) send_item(OP_POP, UID_W'($urandom), $urandom);
    send_item(OP_POP, UID_W'($urandom), $urandom);
  endtask

  // weighted random mix; a narrow uid pool makes duplicates common
  task automatic test_random_mix(input int unsigned n, input int unsigned push_w,
                                 input int unsigned pop_w, input bit narrow);
    int unsigned      r;
    logic [UID_W-1:0] uid;
    repeat (n) begin
      r   = $urandom_range(0, 99);
      uid = narrow ? UID_W'($urandom_range(0, 7)) : UID_W'($urandom_range(0, 255));
      if (r < push_w)
        send_item(OP_PUSH, uid, $urandom);
      else if (r < push_w + pop_w)
        send_item(OP_POP, uid, $urandom);
      else if (r < 95)
        send_item(OP_LOOKUP, ($urandom_range(0, 9) < 7) ? live_uid() : uid, $urandom);
      else
        send_item(OP_UNUSED, uid, $urandom);
    end
  endtask

  initial begin
    err_cnt     = 0;
    no_idle     = 1'b0;
    newest_ptr  = 0;
    oldest_mark = 0;
    foreach (ring_uid[i]) begin
      ring_uid[i]  = '0;
      ring_data[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_ring();
    test_push_lookup();
    test_pop_drain();

    test_overwrite(8);
    no_idle = 1'b1;
    test_overwrite(3);
    no_idle = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      no_idle = (ph == 2);
      if (ph % 2 == 0) test_random_mix(50, 55, 15, ph == 4);
      else             test_random_mix(50, 25, 40, ph == 3);
    end
    no_idle = 1'b0;

    start_i <= 1'b0;
    while (pending_ring_results.size() != 0) @(posedge clk_i);
    repeat (RING_DEPTH + 4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
design/orsk_pkg.sv
design/orsk_ram.sv
design/orsk_ctrl.sv
design/overwrite_ring_stack_key_lookup_core.sv
test/tb_overwrite_ring_stack_key_lookup_core.sv
